@@ sv/sli_pkg.sv @@
// ----------------------------------------------------------------------------
// sli_pkg
// Shared types and codes for the sorted list insert block.
// ----------------------------------------------------------------------------
package sli_pkg;

    localparam int ACT_W    = 2;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 5;

    localparam logic [ACT_W-1:0] ACT_APPEND = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DUMP   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_DUMP,
        S_REPLY
    } t_state;

endpackage

@@ sv/sli_ram.sv @@
// ----------------------------------------------------------------------------
// sli_ram
// Table storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sli_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/sorted_list_insert.sv @@
// ----------------------------------------------------------------------------
// sorted_list_insert
// Ordered table of signed 32-bit values with append, sorted insert, dump and
// clear requests.
// ----------------------------------------------------------------------------
// One request is taken at a time; o_stall stays high until its last result
// has been placed in the output register. Sorted insert walks the table
// through the single read port of the table RAM and one signed comparator:
// it reads entries from the head up to the first entry not smaller than the
// value, then moves each entry from the tail down to that place one place
// toward the tail and writes the new value there; a value larger than every
// entry goes at the tail. Dump gives one result per cycle while the output
// is not stalled. A full table drops the value with status full; a dump of
// an empty table returns one result with status empty.
module sorted_list_insert #(
    parameter int DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [sli_pkg::ACT_W-1:0]           i_action,
    input  logic signed [sli_pkg::DATA_W-1:0]   i_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [sli_pkg::STATUS_W-1:0]        o_status,
    output logic signed [sli_pkg::DATA_W-1:0]   o_entry,
    output logic [sli_pkg::COUNT_W-1:0]         o_count,
    output logic                                o_last
);

    import sli_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);

    t_state                     r_state, n_state;
    logic [FW-1:0]              r_fill, n_fill;
    logic [AW-1:0]              r_idx, n_idx;
    logic [AW-1:0]              r_pos, n_pos;
    logic signed [DATA_W-1:0]   r_value, n_value;
    logic [STATUS_W-1:0]        r_status, n_status;

    logic                       r_ovalid, n_ovalid;
    logic [STATUS_W-1:0]        r_ostatus, n_ostatus;
    logic signed [DATA_W-1:0]   r_oentry, n_oentry;
    logic [COUNT_W-1:0]         r_ocount, n_ocount;
    logic                       r_olast, n_olast;

    logic                       w_we;
    logic [AW-1:0]              w_waddr;
    logic [DATA_W-1:0]          w_wdata;
    logic                       w_re;
    logic [AW-1:0]              w_raddr;
    logic signed [DATA_W-1:0]   w_rdata;

    logic                       w_accept;
    logic                       w_oslot;
    logic                       w_full;
    logic [FW-1:0]              w_fill_p1;
    logic [FW-1:0]              w_fill_m1;
    logic [FW-1:0]              w_idx_p1;
    logic [AW-1:0]              w_idx_m1;
    logic [AW-1:0]              w_idx_m2;
    logic                       w_idx_last;
    logic                       w_less;

    sli_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_W),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_stall    = (r_state != S_IDLE);
    assign w_accept   = i_valid && !o_stall;
    assign w_oslot    = !r_ovalid || !i_stall;
    assign w_full     = (r_fill == FW'(DEPTH));
    assign w_fill_p1  = r_fill + FW'(1);
    assign w_fill_m1  = r_fill - FW'(1);
    assign w_idx_p1   = FW'(r_idx) + FW'(1);
    assign w_idx_m1   = r_idx - AW'(1);
    assign w_idx_m2   = r_idx - AW'(2);
    assign w_idx_last = (w_idx_p1 == r_fill);
    assign w_less     = (w_rdata < r_value);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_pos     <= n_pos;
        r_value   <= n_value;
        r_status  <= n_status;
        r_ostatus <= n_ostatus;
        r_oentry  <= n_oentry;
        r_ocount  <= n_ocount;
        r_olast   <= n_olast;
    end

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_value   = r_value;
        n_status  = r_status;
        n_ovalid  = r_ovalid && i_stall;
        n_ostatus = r_ostatus;
        n_oentry  = r_oentry;
        n_ocount  = r_ocount;
        n_olast   = r_olast;
        w_we      = 1'b0;
        w_waddr   = r_idx;
        w_wdata   = r_value;
        w_re      = 1'b0;
        w_raddr   = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_value  = i_value;
                    n_status = ST_OK;
                    n_state  = S_REPLY;
                    unique case (i_action)
                        ACT_APPEND: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = r_fill[AW-1:0];
                                w_wdata = i_value;
                                n_fill  = w_fill_p1;
                            end
                        end
                        ACT_INSERT: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else if (r_fill == '0) begin
                                w_we    = 1'b1;
                                w_waddr = '0;
                                w_wdata = i_value;
                                n_fill  = w_fill_p1;
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = '0;
                                n_idx   = '0;
                                n_state = S_SEARCH;
                            end
                        end
                        ACT_DUMP: begin
                            if (r_fill == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = '0;
                                n_idx   = '0;
                                n_state = S_DUMP;
                            end
                        end
                        ACT_CLEAR: begin
                            n_fill = '0;
                        end
                        default: begin
                            n_state = S_REPLY;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (!w_less) begin
                    // found the slot, move the tail up one place
                    n_pos   = r_idx;
                    n_idx   = r_fill[AW-1:0];
                    w_re    = 1'b1;
                    w_raddr = w_fill_m1[AW-1:0];
                    n_state = S_SHIFT;
                end else if (w_idx_last) begin
                    w_we    = 1'b1;
                    w_waddr = r_fill[AW-1:0];
                    w_wdata = r_value;
                    n_fill  = w_fill_p1;
                    n_state = S_REPLY;
                end else begin
                    n_idx   = w_idx_p1[AW-1:0];
                    w_re    = 1'b1;
                    w_raddr = w_idx_p1[AW-1:0];
                end
            end
            S_SHIFT: begin
                w_we = 1'b1;
                if (r_idx == r_pos) begin
                    w_waddr = r_pos;
                    w_wdata = r_value;
                    n_fill  = w_fill_p1;
                    n_state = S_REPLY;
                end else begin
                    w_waddr = r_idx;
                    w_wdata = w_rdata;
                    n_idx   = w_idx_m1;
                    w_re    = 1'b1;
                    w_raddr = w_idx_m2;
                end
            end
            S_DUMP: begin
                if (w_oslot) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = ST_OK;
                    n_oentry  = w_rdata;
                    n_ocount  = COUNT_W'(r_fill);
                    n_olast   = w_idx_last;
                    if (w_idx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = w_idx_p1[AW-1:0];
                        w_re    = 1'b1;
                        w_raddr = w_idx_p1[AW-1:0];
                    end
                end
            end
            S_REPLY: begin
                if (w_oslot) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_oentry  = '0;
                    n_ocount  = COUNT_W'(r_fill);
                    n_olast   = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid  = r_ovalid;
    assign o_status = r_ostatus;
    assign o_entry  = r_oentry;
    assign o_count  = r_ocount;
    assign o_last   = r_olast;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DEPTH))
        else $error("fill count beyond table depth");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_action == ACT_CLEAR) |=> (r_fill == '0))
        else $error("clear did not empty the table");

    a_entry_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> (o_entry == '0) && o_last)
        else $error("error result carries an entry or is not last");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_EMPTY) |-> (o_count == '0))
        else $error("empty status with nonzero count");

    a_dump_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last |=> o_valid)
        else $error("dump ended before its last result");
`endif

endmodule

@@ tb/tb_sorted_list_insert.sv @@
// ----------------------------------------------------------------------------
// tb_sorted_list_insert
// Self-checking testbench for the sorted list insert block.
// ----------------------------------------------------------------------------
// Sends append, sorted insert, dump and clear requests and keeps its own copy
// of the ordered list to predict every result. Each result is compared field
// by field against the oldest prediction. The run covers the empty list, the
// signed extremes and equal values, a full list with dropped values, random
// request mixes, a full drain pause, and a last stretch at full rate.
// Random idle bursts on the request side and random stall bursts on the
// result side are used until the last stretch.
// ----------------------------------------------------------------------------
module tb_sorted_list_insert;

    import sli_pkg::*;

    localparam int DEPTH     = 16;
    localparam int MAX_CYCLE = 200000;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'h7fff_ffff;

    typedef struct {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] entry;
        logic [COUNT_W-1:0]       count;
        logic                     last;
    } t_list_reply;

    logic                     i_clk    = 1'b0;
    logic                     i_rst_n  = 1'b0;
    logic                     i_valid  = 1'b0;
    logic [ACT_W-1:0]         i_action = ACT_APPEND;
    logic signed [DATA_W-1:0] i_value  = '0;
    logic                     i_stall  = 1'b0;
    logic                     o_stall;
    logic                     o_valid;
    logic [STATUS_W-1:0]      o_status;
    logic signed [DATA_W-1:0] o_entry;
    logic [COUNT_W-1:0]       o_count;
    logic                     o_last;

    logic signed [DATA_W-1:0] list_vals [DEPTH];
    int                       list_fill = 0;
    t_list_reply              pending_replies [$];
    int                       mismatches = 0;
    int                       cycle_cnt  = 0;
    bit                       bursts_on  = 1'b1;
    int                       stall_left = 0;

    sorted_list_insert #(
        .DEPTH(DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_action(i_action),
        .i_value (i_value),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_status(o_status),
        .o_entry (o_entry),
        .o_count (o_count),
        .o_last  (o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > MAX_CYCLE) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side stall bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall = 1'b1;
            stall_left--;
        end else begin
            i_stall = 1'b0;
            if (bursts_on && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 6);
        end
    end

    always @(posedge i_clk) begin
        t_list_reply exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_replies.size() == 0) begin
                $error("unexpected result: status %0d entry %0d count %0d last %0d",
                       o_status, o_entry, o_count, o_last);
                mismatches++;
            end else begin
                exp_r = pending_replies.pop_front();
                if (o_status !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, o_status);
                    mismatches++;
                end
                if (o_entry !== exp_r.entry) begin
                    $error("entry: expected %0d, got %0d", exp_r.entry, o_entry);
                    mismatches++;
                end
                if (o_count !== exp_r.count) begin
                    $error("count: expected %0d, got %0d", exp_r.count, o_count);
                    mismatches++;
                end
                if (o_last !== exp_r.last) begin
                    $error("last: expected %0d, got %0d", exp_r.last, o_last);
                    mismatches++;
                end
            end
        end
    end

    function automatic void push_reply(input logic [STATUS_W-1:0] status,
                                       input logic signed [DATA_W-1:0] entry,
                                       input logic last);
        t_list_reply r;
        r.status = status;
        r.entry  = entry;
        r.count  = COUNT_W'(list_fill);
        r.last   = last;
        pending_replies.push_back(r);
    endfunction

    function automatic void predict_list_action(input logic [ACT_W-1:0] action,
                                                input logic signed [DATA_W-1:0] value);
        int pos;
        case (action)
            ACT_APPEND: begin
                if (list_fill >= DEPTH) begin
                    push_reply(ST_FULL, '0, 1'b1);
                end else begin
                    list_vals[list_fill] = value;
                    list_fill++;
                    push_reply(ST_OK, '0, 1'b1);
                end
            end
            ACT_INSERT: begin
                if (list_fill >= DEPTH) begin
                    push_reply(ST_FULL, '0, 1'b1);
                end else begin
                    pos = list_fill;
                    for (int i = 0; i < list_fill; i++) begin
                        if (!(list_vals[i] < value)) begin
                            pos = i;
                            break;
                        end
                    end
                    for (int i = list_fill; i > pos; i--)
                        list_vals[i] = list_vals[i-1];
                    list_vals[pos] = value;
                    list_fill++;
                    push_reply(ST_OK, '0, 1'b1);
                end
            end
            ACT_DUMP: begin
                if (list_fill == 0) begin
                    push_reply(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (int i = 0; i < list_fill; i++)
                        push_reply(ST_OK, list_vals[i], i + 1 == list_fill);
                end
            end
            default: begin
                list_fill = 0;
                push_reply(ST_OK, '0, 1'b1);
            end
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 3))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return '0;
                    default: return -1;
                endcase
            end
            1: return $signed($urandom_range(0, 6)) - 3;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(input logic [ACT_W-1:0] action,
                                input logic signed [DATA_W-1:0] value);
        int gap;
        if (bursts_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                i_valid  = 1'b0;
                i_action = ACT_W'($urandom_range(0, 3));
                i_value  = $urandom;
            end
        end
        @(negedge i_clk);
        i_valid  = 1'b1;
        i_action = action;
        i_value  = value;
        do @(posedge i_clk); while (o_stall);
        predict_list_action(action, value);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_replies.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic send_random_request();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            send_request(ACT_INSERT, pick_value());
        else if (pick < 70)
            send_request(ACT_APPEND, pick_value());
        else if (pick < 92)
            send_request(ACT_DUMP, $urandom);
        else
            send_request(ACT_CLEAR, $urandom);
    endtask

    task automatic test_empty_list();
        send_request(ACT_DUMP, $urandom);
        send_request(ACT_CLEAR, $urandom);
        send_request(ACT_DUMP, $urandom);
    endtask

    // signed extremes, equal values and unsorted appends
    task automatic test_signed_extremes();
        send_request(ACT_INSERT, '0);
        send_request(ACT_INSERT, VAL_MIN);
        send_request(ACT_INSERT, VAL_MAX);
        send_request(ACT_INSERT, '0);
        send_request(ACT_INSERT, VAL_MIN);
        send_request(ACT_INSERT, 32'h5555_5555);
        send_request(ACT_APPEND, 32'haaaa_aaaa);
        send_request(ACT_APPEND, VAL_MAX);
        send_request(ACT_INSERT, -1);
        send_request(ACT_DUMP, $urandom);
        send_request(ACT_CLEAR, $urandom);
    endtask

    task automatic test_full_list();
        for (int i = 0; i < DEPTH; i++)
            send_request($urandom_range(0, 3) == 0 ? ACT_APPEND : ACT_INSERT, pick_value());
        send_request(ACT_APPEND, pick_value());
        send_request(ACT_INSERT, pick_value());
        send_request(ACT_DUMP, $urandom);
        send_request(ACT_CLEAR, $urandom);
        send_request(ACT_DUMP, $urandom);
    endtask

    task automatic test_random_mix(input int n);
        repeat (n)
            send_random_request();
    endtask

    task automatic test_drain_pause();
        wait_drained();
        send_request(ACT_DUMP, $urandom);
        send_request(ACT_INSERT, pick_value());
    endtask

    task automatic test_full_rate(input int n);
        bursts_on = 1'b0;
        repeat (n)
            send_random_request();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_list();
        test_signed_extremes();
        test_full_list();
        test_random_mix(40);
        test_drain_pause();
        test_random_mix(25);
        test_full_rate(30);

        wait_drained();
        repeat (2 * DEPTH + 8) @(posedge i_clk);
        if (mismatches == 0 && pending_replies.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
